FILE: sv/mbrot_pkg.sv
// Shared types and constants for the escape-time iteration block.
`default_nettype none

package mbrot_pkg;

   localparam int COORD_WIDTH = 9;
   localparam int VALUE_WIDTH = 32;
   localparam int PROD_WIDTH  = 64;
   localparam int FRAC_BITS   = 28;
   localparam int SQUARE_WIDTH = 35;
   localparam int MAG_WIDTH    = 36;
   localparam int COUNT_WIDTH  = 8;
   localparam int CSR_INDEX_WIDTH = 8;

   localparam logic [MAG_WIDTH-1:0]   ESCAPE_LIMIT = MAG_WIDTH'(64'd1 << (FRAC_BITS + 2));
   localparam logic [COUNT_WIDTH-1:0] NO_ESCAPE    = 8'd255;

   localparam logic signed [VALUE_WIDTH-1:0] REAL_ORIGIN_RESET = -32'sd536870912;
   localparam logic signed [VALUE_WIDTH-1:0] REAL_STEP_RESET   = 32'sd2097152;
   localparam logic signed [VALUE_WIDTH-1:0] IMAG_ORIGIN_RESET = 32'sd536870912;
   localparam logic signed [VALUE_WIDTH-1:0] IMAG_STEP_RESET   = -32'sd2097152;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_REAL_ORIGIN = 8'd0,
      REG_REAL_STEP   = 8'd1,
      REG_IMAG_ORIGIN = 8'd2,
      REG_IMAG_STEP   = 8'd3
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_CX,
      ST_MUL_CY,
      ST_LOAD_CY,
      ST_UPDATE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_CROSS,
      ST_TEST,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_MUL_CX,
      OP_MUL_CY,
      OP_LOAD_CY,
      OP_UPDATE,
      OP_SQ_X,
      OP_SQ_Y,
      OP_CROSS,
      OP_TEST
   } dp_op_type;

   typedef struct packed {
      logic      capture;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic escape;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: sv/mandelbrot_escape_time_top.sv
// Top level of the escape-time iteration block: controller plus datapath.
//
// Each request carries one pixel position (req_column, req_row). The block maps it
// to the complex point c = (real_origin + real_step * column,
// imag_origin + imag_step * row) and iterates z = z*z + c from zero in signed
// Q4.28, returning on the rsp_ channel the index of the first round whose |z|^2
// exceeds 4, or 255 when z stays bounded for all MAX_ROUNDS rounds.
// The csr_ channel writes the four coordinate registers; it is always ready and
// should only be used while no request is in flight.
// A request whose z escapes in round k is answered after its mapping and k+1
// rounds, so after at most MAX_ROUNDS rounds. Each round runs the UPDATE, SQ_X,
// SQ_Y, CROSS and TEST states, as one 32x32 multiplier forms zx*zx, zy*zy and
// zx*zy in turn, with an update step before them and a test step after; the
// MUL_CX, MUL_CY and LOAD_CY states first map the coordinate through the same
// multiplier, and DONE loads the result. Requests are worked on one at a time:
// the next one is accepted at the earliest as soon as the previous response is
// in the output register, even if the receiver has not taken it yet. If
// rsp_ready stays low, the next result waits until the output register frees,
// and the response holds steady meanwhile. Reset returns the registers to their
// defaults, idles the sequencer and drops rsp_valid; no clearing pass is needed.
`default_nettype none

module mandelbrot_escape_time_top #(
   parameter int MAX_ROUNDS = 256
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  [mbrot_pkg::COORD_WIDTH-1:0]     req_column,
   input  wire  [mbrot_pkg::COORD_WIDTH-1:0]     req_row,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic [mbrot_pkg::COUNT_WIDTH-1:0]     rsp_escape_count,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [mbrot_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire  [mbrot_pkg::VALUE_WIDTH-1:0]     csr_data
);
   import mbrot_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Register writes never stall.
   assign csr_ready = 1'b1;

   mbrot_ctrl #(
      .MAX_ROUNDS(MAX_ROUNDS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_escape_count (rsp_escape_count),
      .status           (status),
      .cmd              (cmd)
   );

   mbrot_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_column (req_column),
      .req_row    (req_row),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

FILE: sv/mbrot_dp.sv
// Datapath: configuration registers, shared multiplier and the z iteration registers.
`default_nettype none

module mbrot_dp (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_valid,
   input  wire  [mbrot_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire  [mbrot_pkg::VALUE_WIDTH-1:0]   csr_data,
   input  wire  [mbrot_pkg::COORD_WIDTH-1:0]   req_column,
   input  wire  [mbrot_pkg::COORD_WIDTH-1:0]   req_row,
   input  mbrot_pkg::dp_cmd_type               cmd,
   output mbrot_pkg::dp_status_type            status
);
   import mbrot_pkg::*;

   logic signed [VALUE_WIDTH-1:0] real_origin_ff, real_step_ff;
   logic signed [VALUE_WIDTH-1:0] imag_origin_ff, imag_step_ff;

   logic [COORD_WIDTH-1:0]        col_ff, row_ff;
   logic signed [PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic signed [VALUE_WIDTH-1:0] mul_a, mul_b;
   logic [VALUE_WIDTH-1:0]        cx_ff, cy_ff, zx_ff, zy_ff, xy2_ff;
   logic [SQUARE_WIDTH-1:0]       xx_ff, yy_ff;
   logic [MAG_WIDTH-1:0]          mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         real_origin_ff <= REAL_ORIGIN_RESET;
         real_step_ff   <= REAL_STEP_RESET;
         imag_origin_ff <= IMAG_ORIGIN_RESET;
         imag_step_ff   <= IMAG_STEP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_REAL_ORIGIN: real_origin_ff <= csr_data;
            REG_REAL_STEP:   real_step_ff   <= csr_data;
            REG_IMAG_ORIGIN: imag_origin_ff <= csr_data;
            REG_IMAG_STEP:   imag_step_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // One signed 32x32 multiplier serves the coordinate mapping and all three products.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MUL_CX: begin
            mul_a = real_step_ff;
            mul_b = $signed(VALUE_WIDTH'(col_ff));
         end
         OP_MUL_CY: begin
            mul_a = imag_step_ff;
            mul_b = $signed(VALUE_WIDTH'(row_ff));
         end
         OP_SQ_X: begin
            mul_a = $signed(zx_ff);
            mul_b = $signed(zx_ff);
         end
         OP_SQ_Y: begin
            mul_a = $signed(zy_ff);
            mul_b = $signed(zy_ff);
         end
         OP_CROSS: begin
            mul_a = $signed(zx_ff);
            mul_b = $signed(zy_ff);
         end
         default: ;
      endcase
      prod_in = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         col_ff <= req_column;
         row_ff <= req_row;
         xx_ff  <= '0;
         yy_ff  <= '0;
         xy2_ff <= '0;
      end
      case (cmd.op)
         OP_MUL_CX: prod_ff <= prod_in;
         OP_MUL_CY: begin
            cx_ff   <= real_origin_ff + prod_ff[VALUE_WIDTH-1:0];
            prod_ff <= prod_in;
         end
         OP_LOAD_CY: cy_ff <= imag_origin_ff + prod_ff[VALUE_WIDTH-1:0];
         OP_UPDATE: begin
            zx_ff <= xx_ff[VALUE_WIDTH-1:0] - yy_ff[VALUE_WIDTH-1:0] + cx_ff;
            zy_ff <= xy2_ff + cy_ff;
         end
         OP_SQ_X: prod_ff <= prod_in;
         OP_SQ_Y: begin
            // Squares are never negative, so the floor shift is a plain slice.
            xx_ff   <= prod_ff[FRAC_BITS+SQUARE_WIDTH-1:FRAC_BITS];
            prod_ff <= prod_in;
         end
         OP_CROSS: begin
            yy_ff   <= prod_ff[FRAC_BITS+SQUARE_WIDTH-1:FRAC_BITS];
            prod_ff <= prod_in;
         end
         OP_TEST: xy2_ff <= prod_ff[FRAC_BITS+VALUE_WIDTH-2:FRAC_BITS-1];
         default: ;
      endcase
   end

   assign mag           = MAG_WIDTH'(xx_ff) + MAG_WIDTH'(yy_ff);
   assign status.escape = (mag > ESCAPE_LIMIT);

endmodule

`default_nettype wire

FILE: sv/mbrot_ctrl.sv
// Controller: sequencing state machine, round counter and result register.
`default_nettype none

module mbrot_ctrl #(
   parameter int MAX_ROUNDS = 256
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [mbrot_pkg::COUNT_WIDTH-1:0] rsp_escape_count,
   input  mbrot_pkg::dp_status_type          status,
   output mbrot_pkg::dp_cmd_type             cmd
);
   import mbrot_pkg::*;

   localparam int ROUND_WIDTH = $clog2(MAX_ROUNDS);

   state_type                  state_ff, state_in;
   logic [ROUND_WIDTH-1:0]     round_ff, round_in;
   logic                       escaped_ff, escaped_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH-1:0]     rsp_count_ff, rsp_count_in;
   logic                       last_round, finish, slot_free;
   logic                       round_clear, round_inc, escaped_load, rsp_load;

   assign last_round = (round_ff == ROUND_WIDTH'(MAX_ROUNDS - 1));
   assign finish     = status.escape || last_round;
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_MUL_CX;
         ST_MUL_CX:  state_in = ST_MUL_CY;
         ST_MUL_CY:  state_in = ST_LOAD_CY;
         ST_LOAD_CY: state_in = ST_UPDATE;
         ST_UPDATE:  state_in = ST_SQ_X;
         ST_SQ_X:    state_in = ST_SQ_Y;
         ST_SQ_Y:    state_in = ST_CROSS;
         ST_CROSS:   state_in = ST_TEST;
         ST_TEST:    state_in = finish ? ST_DONE : ST_UPDATE;
         ST_DONE:    if (slot_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.capture  = 1'b0;
      cmd.op       = OP_NOP;
      round_clear  = 1'b0;
      round_inc    = 1'b0;
      escaped_load = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            round_clear = req_valid;
         end
         ST_MUL_CX:  cmd.op = OP_MUL_CX;
         ST_MUL_CY:  cmd.op = OP_MUL_CY;
         ST_LOAD_CY: cmd.op = OP_LOAD_CY;
         ST_UPDATE:  cmd.op = OP_UPDATE;
         ST_SQ_X:    cmd.op = OP_SQ_X;
         ST_SQ_Y:    cmd.op = OP_SQ_Y;
         ST_CROSS:   cmd.op = OP_CROSS;
         ST_TEST: begin
            cmd.op       = OP_TEST;
            escaped_load = 1'b1;
            round_inc    = !finish;
         end
         ST_DONE:    rsp_load = slot_free;
         default: ;
      endcase
   end

   always_comb begin
      round_in = round_ff;
      if (round_clear) begin
         round_in = '0;
      end else if (round_inc) begin
         round_in = round_ff + ROUND_WIDTH'(1);
      end
      escaped_in   = escaped_load ? status.escape : escaped_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = escaped_ff ? COUNT_WIDTH'(round_ff) : NO_ESCAPE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      round_ff     <= round_in;
      escaped_ff   <= escaped_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_escape_count = rsp_count_ff;

endmodule

`default_nettype wire

FILE: sv/mbrot_checker.sv
// Port-level checks for the escape-time block and the bind that attaches them.
`default_nettype none

module mbrot_checker (
   input wire                                   clock,
   input wire                                   reset,
   input wire                                   req_valid,
   input wire                                   req_ready,
   input wire                                   rsp_valid,
   input wire                                   rsp_ready,
   input wire  [mbrot_pkg::COUNT_WIDTH-1:0]     rsp_escape_count
);

   // A stalled response keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_escape_count))
      else $error("stalled response changed");

   // Only one request is worked on at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // No response can follow a request in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response appeared too early");

   // A new response only appears while the block is busy with a request.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response without work in progress");

endmodule

bind mandelbrot_escape_time_top mbrot_checker u_mbrot_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_escape_count (rsp_escape_count)
);

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the escape-time iteration block: directed table plus random views.
`default_nettype none

module tb_top;

   import mbrot_pkg::*;

   // Number of iteration rounds of the block, and a wait that outlasts its slowest request.
   localparam int MAX_ROUNDS    = 256;
   localparam int SETTLE_CYCLES = 5 * MAX_ROUNDS + 20;

   // Random idle draws per request, the long receiver hold-off and the watchdog limit.
   // The watchdog assumes every request runs all rounds and meets the longest gap on both
   // sides, then takes that several times over.
   localparam int MAX_GAP       = 17;
   localparam int LONG_HOLD     = 3000;
   localparam int CYCLE_LIMIT   = 4_000_000;

   // Random part: several views of the complex plane, each with a batch of requests.
   localparam int NUM_VIEWS      = 12;
   localparam int PIXELS_PER_VIEW = 50;
   localparam int HOLD_VIEW      = 5;
   localparam int STEADY_VIEW    = 8;

   // Register indexes outside the decoded range, which the block must ignore.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNMAPPED_FIRST = 8'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNMAPPED_LAST  = 8'd255;

   // Q4.28 values used at both ends of the register range and at zero.
   localparam logic [VALUE_WIDTH-1:0] Q_MAX  = 32'h7FFF_FFFF;
   localparam logic [VALUE_WIDTH-1:0] Q_MIN  = 32'h8000_0000;
   localparam logic [VALUE_WIDTH-1:0] Q_ZERO = 32'h0000_0000;

   // Marker in the directed table for rows whose count comes from the predictor.
   localparam int PREDICT = -1;

   typedef enum logic {
      STEP_PIXEL,
      STEP_CSR
   } step_kind_e;

   // One row of the directed table: either a pixel request or a register write.
   typedef struct packed {
      step_kind_e                 kind;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [VALUE_WIDTH-1:0]     data;
      logic [COORD_WIDTH-1:0]     column;
      logic [COORD_WIDTH-1:0]     row;
      int                         known;
   } plan_step_t;

   typedef enum int {
      VIEW_DEFAULT,
      VIEW_ZOOM,
      VIEW_WILD,
      VIEW_EDGE,
      VIEW_EXTREME
   } view_e;

   typedef struct {
      logic [COORD_WIDTH-1:0] column;
      logic [COORD_WIDTH-1:0] row;
      logic [COUNT_WIDTH-1:0] count;
   } escape_expect_t;

   localparam int NUM_DIRECTED = 31;

   // The rows with a typed count can be worked out by hand. Under the reset view, pixel
   // (256,256) is c = 0 and (128,256) is c = -1, both bounded. Pixel (384,256) is c = 1,
   // where |z|^2 reaches exactly 4 in the second round and only escapes in the third.
   // Pixel (256,0) is c = 2i, again exactly 4 in the first round. Pixel (0,256) is c = -2,
   // which sits at z = 2 forever without ever exceeding the limit.
   plan_step_t directed_plan [NUM_DIRECTED] = '{
      '{STEP_PIXEL, REG_REAL_ORIGIN,    Q_ZERO, 9'd0,   9'd0,   0},
      '{STEP_PIXEL, REG_REAL_ORIGIN,    Q_ZERO, 9'd511, 9'd511, 0},
      '{STEP_PIXEL, REG_REAL_ORIGIN,    Q_ZERO, 9'd256, 9'd256, 255},
      '{STEP_PIXEL, REG_REAL_ORIGIN,    Q_ZERO, 9'd384, 9'd256, 2},
      '{STEP_PIXEL, REG_REAL_ORIGIN,    Q_ZERO, 9'd256, 9'd0,   1},
      '{STEP_PIXEL, REG_REAL_ORIGIN,    Q_ZERO, 9'd0,   9'd256, 255},
      '{STEP_PIXEL, REG_REAL_ORIGIN,    Q_ZERO, 9'd128, 9'd256, 255},
      '{STEP_PIXEL, REG_REAL_ORIGIN,    Q_ZERO, 9'd300, 9'd200, PREDICT},
      '{STEP_PIXEL, REG_REAL_ORIGIN,    Q_ZERO, 9'd341, 9'd170, PREDICT},
      '{STEP_PIXEL, REG_REAL_ORIGIN,    Q_ZERO, 9'd170, 9'd341, PREDICT},
      // Collapse the view onto the origin: every pixel is c = 0.
      '{STEP_CSR,   REG_REAL_ORIGIN,    Q_ZERO, 9'd0,   9'd0,   PREDICT},
      '{STEP_CSR,   REG_REAL_STEP,      Q_ZERO, 9'd0,   9'd0,   PREDICT},
      '{STEP_CSR,   REG_IMAG_ORIGIN,    Q_ZERO, 9'd0,   9'd0,   PREDICT},
      '{STEP_CSR,   REG_IMAG_STEP,      Q_ZERO, 9'd0,   9'd0,   PREDICT},
      '{STEP_PIXEL, REG_REAL_ORIGIN,    Q_ZERO, 9'd511, 9'd511, 255},
      // Writes to unmapped indexes must leave the view untouched.
      '{STEP_CSR,   REG_UNMAPPED_FIRST, Q_MAX,  9'd0,   9'd0,   PREDICT},
      '{STEP_CSR,   REG_UNMAPPED_LAST,  Q_MAX,  9'd0,   9'd0,   PREDICT},
      '{STEP_PIXEL, REG_REAL_ORIGIN,    Q_ZERO, 9'd511, 9'd511, 255},
      // Origins at both ends of the range escape in the very first round.
      '{STEP_CSR,   REG_REAL_ORIGIN,    Q_MAX,  9'd0,   9'd0,   PREDICT},
      '{STEP_PIXEL, REG_REAL_ORIGIN,    Q_ZERO, 9'd0,   9'd0,   0},
      '{STEP_CSR,   REG_REAL_ORIGIN,    Q_MIN,  9'd0,   9'd0,   PREDICT},
      '{STEP_PIXEL, REG_REAL_ORIGIN,    Q_ZERO, 9'd0,   9'd0,   0},
      // Steps at both ends of the range make the coordinate sums wrap.
      '{STEP_CSR,   REG_REAL_ORIGIN,    REAL_ORIGIN_RESET, 9'd0, 9'd0, PREDICT},
      '{STEP_CSR,   REG_REAL_STEP,      Q_MAX,  9'd0,   9'd0,   PREDICT},
      '{STEP_CSR,   REG_IMAG_STEP,      Q_MIN,  9'd0,   9'd0,   PREDICT},
      '{STEP_PIXEL, REG_REAL_ORIGIN,    Q_ZERO, 9'd511, 9'd511, PREDICT},
      '{STEP_PIXEL, REG_REAL_ORIGIN,    Q_ZERO, 9'd1,   9'd1,   PREDICT},
      '{STEP_CSR,   REG_REAL_STEP,      Q_MIN,  9'd0,   9'd0,   PREDICT},
      '{STEP_CSR,   REG_IMAG_STEP,      Q_MAX,  9'd0,   9'd0,   PREDICT},
      '{STEP_CSR,   REG_IMAG_ORIGIN,    Q_MIN,  9'd0,   9'd0,   PREDICT},
      '{STEP_PIXEL, REG_REAL_ORIGIN,    Q_ZERO, 9'd511, 9'd3,   PREDICT}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid  = 1'b0;
   logic                       req_ready;
   logic [COORD_WIDTH-1:0]     req_column = '0;
   logic [COORD_WIDTH-1:0]     req_row    = '0;
   logic                       rsp_valid;
   logic                       rsp_ready  = 1'b0;
   logic [COUNT_WIDTH-1:0]     rsp_escape_count;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [VALUE_WIDTH-1:0]     csr_data   = '0;

   // Shadow copy of the view registers, kept in step with every accepted write.
   logic signed [VALUE_WIDTH-1:0] real_origin_q = REAL_ORIGIN_RESET;
   logic signed [VALUE_WIDTH-1:0] real_step_q   = REAL_STEP_RESET;
   logic signed [VALUE_WIDTH-1:0] imag_origin_q = IMAG_ORIGIN_RESET;
   logic signed [VALUE_WIDTH-1:0] imag_step_q   = IMAG_STEP_RESET;

   // Counts still owed by the block, oldest first.
   escape_expect_t expected_escapes [$];

   int  error_count = 0;
   int  cycle_count = 0;

   // Set by the stimulus side: steady turns off idling on both sides, hold_pending asks the
   // receiver for one long hold-off.
   bit  steady       = 1'b0;
   bit  hold_pending = 1'b0;

   mandelbrot_escape_time_top #(
      .MAX_ROUNDS(MAX_ROUNDS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_column       (req_column),
      .req_row          (req_row),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_escape_count (rsp_escape_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Escape round of one pixel under the current shadow view. The coordinate sums and the
   // z updates keep only their low 32 bits; products are exact in 64 bits and the
   // arithmetic right shift floors them back to Q4.28.
   function automatic logic [COUNT_WIDTH-1:0] escape_round(input logic [COORD_WIDTH-1:0] column,
                                                           input logic [COORD_WIDTH-1:0] row);
      logic signed [VALUE_WIDTH-1:0] cx, cy, zx, zy;
      longint                        xx, yy, xy2, mag;
      logic [COUNT_WIDTH-1:0]        found;
      found = NO_ESCAPE;
      cx = VALUE_WIDTH'(longint'(real_origin_q) + longint'(real_step_q) * longint'(column));
      cy = VALUE_WIDTH'(longint'(imag_origin_q) + longint'(imag_step_q) * longint'(row));
      zx = '0;
      zy = '0;
      for (int round = 0; round < MAX_ROUNDS; round++) begin
         xx  = (longint'(zx) * longint'(zx)) >>> FRAC_BITS;
         yy  = (longint'(zy) * longint'(zy)) >>> FRAC_BITS;
         xy2 = (longint'(zx) * longint'(zy)) >>> (FRAC_BITS - 1);
         zx  = VALUE_WIDTH'(xx - yy + longint'(cx));
         zy  = VALUE_WIDTH'(xy2 + longint'(cy));
         mag = ((longint'(zx) * longint'(zx)) >>> FRAC_BITS)
             + ((longint'(zy) * longint'(zy)) >>> FRAC_BITS);
         if (mag > longint'(ESCAPE_LIMIT)) begin
            found = COUNT_WIDTH'(round);
            break;
         end
      end
      return found;
   endfunction

   // Offers one pixel request after a random gap and records its expected count once the
   // block takes it. Valid stays high across back-to-back requests with no gap.
   task automatic offer_pixel(input logic [COORD_WIDTH-1:0] column,
                              input logic [COORD_WIDTH-1:0] row, input int known);
      int             gap;
      escape_expect_t entry;
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_column <= column;
      req_row    <= row;
      do @(posedge clock); while (!req_ready);
      entry.column = column;
      entry.row    = row;
      entry.count  = (known == PREDICT) ? escape_round(column, row) : COUNT_WIDTH'(known);
      expected_escapes.push_back(entry);
   endtask

   // Stops offering requests and waits until every expected count has come back, so that
   // the block is idle.
   task automatic drain_requests();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_escapes.size() != 0);
   endtask

   // Writes one register and mirrors it in the shadow view; unmapped indexes are dropped.
   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [VALUE_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         REG_REAL_ORIGIN: real_origin_q = data;
         REG_REAL_STEP:   real_step_q   = data;
         REG_IMAG_ORIGIN: imag_origin_q = data;
         REG_IMAG_STEP:   imag_step_q   = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [VALUE_WIDTH-1:0] signed_span(input int limit);
      int magnitude;
      magnitude = $urandom_range(0, limit);
      return $urandom_range(0, 1) ? VALUE_WIDTH'(-magnitude) : VALUE_WIDTH'(magnitude);
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] extreme_value();
      case ($urandom_range(0, 3))
         0:       return Q_MAX;
         1:       return Q_MIN;
         2:       return Q_ZERO;
         default: return VALUE_WIDTH'($urandom());
      endcase
   endfunction

   // Programs one view of the plane. The zoom view spans a window of up to about four units
   // around the set, the edge view a narrow window near the neck of the set where many
   // points need long runs, and the wild and extreme views take values from the whole range.
   task automatic program_view(input view_e view);
      logic [VALUE_WIDTH-1:0] values [4];
      case (view)
         VIEW_DEFAULT: begin
            values = '{REAL_ORIGIN_RESET, REAL_STEP_RESET, IMAG_ORIGIN_RESET, IMAG_STEP_RESET};
         end
         VIEW_ZOOM: begin
            values[0] = VALUE_WIDTH'($urandom_range(0, 939524096)) - 32'd671088640;
            values[1] = signed_span(2097152);
            values[2] = VALUE_WIDTH'($urandom_range(0, 805306368)) - 32'd402653184;
            values[3] = signed_span(2097152);
         end
         VIEW_EDGE: begin
            values[0] = -32'sd201326592 + signed_span(1048576);
            values[1] = signed_span(16384);
            values[2] = 32'sd26843545 + signed_span(1048576);
            values[3] = signed_span(16384);
         end
         VIEW_EXTREME: begin
            foreach (values[k]) values[k] = extreme_value();
         end
         default: begin
            foreach (values[k]) values[k] = VALUE_WIDTH'($urandom());
         end
      endcase
      csr_write(REG_REAL_ORIGIN, values[0]);
      csr_write(REG_REAL_STEP,   values[1]);
      csr_write(REG_IMAG_ORIGIN, values[2]);
      csr_write(REG_IMAG_STEP,   values[3]);
      // Now and then a stray write to an unmapped index, which must change nothing.
      if ($urandom_range(0, 3) == 0) begin
         csr_write(CSR_INDEX_WIDTH'($urandom_range(REG_UNMAPPED_FIRST, REG_UNMAPPED_LAST)),
                   VALUE_WIDTH'($urandom()));
      end
   endtask

   // Main stimulus: reset, the directed table, then the random views, and the final check.
   initial begin : stimulus
      view_e view;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register writes in the table only happen once the block has gone idle.
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == STEP_CSR) begin
            drain_requests();
            csr_write(directed_plan[i].index, directed_plan[i].data);
         end else begin
            offer_pixel(directed_plan[i].column, directed_plan[i].row, directed_plan[i].known);
         end
      end

      for (int v = 0; v < NUM_VIEWS; v++) begin
         // Every view change is a pause until the block has returned every count.
         drain_requests();
         if (v == 0) begin
            view = VIEW_DEFAULT;
         end else if (v == HOLD_VIEW) begin
            view = VIEW_WILD;
         end else begin
            view = view_e'($urandom_range(VIEW_DEFAULT, VIEW_EXTREME));
         end
         program_view(view);
         steady = (v == STEADY_VIEW);
         // In the hold view the receiver stops taking responses while requests keep coming,
         // so the block fills its output register and stalls its input.
         if (v == HOLD_VIEW) begin
            hold_pending = 1'b1;
         end
         for (int n = 0; n < PIXELS_PER_VIEW; n++) begin
            offer_pixel(COORD_WIDTH'($urandom_range(0, 511)),
                        COORD_WIDTH'($urandom_range(0, 511)), PREDICT);
         end
      end
      steady = 1'b0;

      // Let any stray response surface before the verdict.
      drain_requests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_escapes.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Receiver: random stalls between responses, or one long hold-off when asked for.
   initial begin : response_side
      int stall;
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            stall = LONG_HOLD;
         end else begin
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // Compares each accepted response with the oldest expected count.
   always @(posedge clock) begin
      escape_expect_t entry;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_escapes.size() == 0) begin
            $display("%0t: response %0d with no request outstanding", $time, rsp_escape_count);
            error_count++;
         end else begin
            entry = expected_escapes.pop_front();
            if (rsp_escape_count !== entry.count) begin
               $display("%0t: pixel (%0d,%0d) escape count expected %0d, actual %0d",
                        $time, entry.column, entry.row, entry.count, rsp_escape_count);
               error_count++;
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule

`default_nettype wire
